### rtl/crp_pkg.sv
// Shared types and codes for the completion ring purge block.
package crp_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_POLL  = 2'd1;
    localparam logic [1:0] ACT_CLEAN = 2'd2;

    localparam logic [1:0] ST_WRITTEN = 2'd0;
    localparam logic [1:0] ST_POLLED  = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_CLEANED = 2'd3;

    localparam logic [3:0] LOG2_MIN   = 4'd1;
    localparam logic [3:0] LOG2_MAX   = 4'd8;
    localparam logic [3:0] LOG2_RESET = 4'd8;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  slot;
        logic [23:0] pair_number;
        logic [31:0] entry_payload;
        logic        hw_owned;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] out_pair_number;
        logic [31:0] out_payload;
        logic [7:0]  freed_count;
        logic [15:0] consumer_position;
    } rsp_t;

    typedef struct packed {
        logic [23:0] pair;
        logic [31:0] payload;
    } entry_t;

endpackage

### rtl/crp_ring_mem.sv
// Ring entry store: one write port, one registered read port.
module crp_ring_mem
    import crp_pkg::*;
#(
    parameter int IDX_W = 8
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    localparam int DEPTH = 1 << IDX_W;

    entry_t mem [0:DEPTH-1];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/crp_ctrl.sv
// Sequencer for write, poll and clean actions, with owner flags and result register.
module crp_ctrl
    import crp_pkg::*;
#(
    parameter int IDX_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] mask,
    input  logic             req_valid,
    output logic             req_stall,
    input  req_t             req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output rsp_t             rsp,
    output logic             mem_wr_en,
    output logic [IDX_W-1:0] mem_wr_addr,
    output entry_t           mem_wr_data,
    output logic             mem_rd_en,
    output logic [IDX_W-1:0] mem_rd_addr,
    input  entry_t           mem_rd_data
);

    localparam int DEPTH = 1 << IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POLL_RD,
        S_SCAN,
        S_SWEEP_RD,
        S_SWEEP_WB,
        S_RELEASE,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    req_t             item_reg, item_next;
    rsp_t             res_reg, res_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [DEPTH-1:0] sw_reg, sw_next;
    logic [15:0]      ci_reg, ci_next;
    logic [IDX_W-1:0] run_reg, run_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] freed_reg, freed_next;

    logic [IDX_W-1:0] ci_slot;
    logic [IDX_W-1:0] scan_idx;
    logic [IDX_W-1:0] sweep_idx;
    logic [IDX_W-1:0] move_idx;
    logic [IDX_W-1:0] rel_idx;

    assign ci_slot   = ci_reg[IDX_W-1:0] & mask;
    assign scan_idx  = (ci_reg[IDX_W-1:0] + run_reg) & mask;
    assign sweep_idx = (ci_reg[IDX_W-1:0] + k_reg - 1'b1) & mask;
    assign move_idx  = (sweep_idx + freed_reg) & mask;
    assign rel_idx   = (ci_reg[IDX_W-1:0] + k_reg) & mask;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        sw_next        = sw_reg;
        ci_next        = ci_reg;
        run_next       = run_reg;
        k_next         = k_reg;
        freed_next     = freed_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = sweep_idx;
        mem_wr_data    = mem_rd_data;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = sweep_idx;
        req_stall      = (state_reg != S_IDLE);

        // drop the result once the far side has taken it
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                res_next                   = '0;
                res_next.consumer_position = ci_reg;
                state_next                 = S_DONE;
                unique case (item_reg.action)
                    ACT_WRITE:
                    begin
                        mem_wr_en           = 1'b1;
                        mem_wr_addr         = item_reg.slot[IDX_W-1:0] & mask;
                        mem_wr_data.pair    = item_reg.pair_number;
                        mem_wr_data.payload = item_reg.entry_payload;
                        sw_next[item_reg.slot[IDX_W-1:0] & mask] = !item_reg.hw_owned;
                        res_next.status     = ST_WRITTEN;
                    end
                    ACT_POLL:
                    begin
                        if (sw_reg[ci_slot])
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = ci_slot;
                            state_next  = S_POLL_RD;
                        end
                        else
                        begin
                            res_next.status = ST_EMPTY;
                        end
                    end
                    ACT_CLEAN:
                    begin
                        run_next   = '0;
                        freed_next = '0;
                        state_next = S_SCAN;
                    end
                    default:
                    begin
                        res_next.status = ST_WRITTEN;
                    end
                endcase
            end

            S_POLL_RD:
            begin
                sw_next[ci_slot]           = 1'b0;
                ci_next                    = ci_reg + 16'd1;
                res_next.status            = ST_POLLED;
                res_next.out_pair_number   = mem_rd_data.pair;
                res_next.out_payload       = mem_rd_data.payload;
                res_next.consumer_position = ci_reg + 16'd1;
                state_next                 = S_DONE;
            end

            S_SCAN:
            begin
                // measure the software-owned run, capped one short of the ring
                if ((run_reg < mask) && sw_reg[scan_idx])
                begin
                    run_next = run_reg + 1'b1;
                end
                else
                begin
                    k_next     = run_reg;
                    state_next = S_SWEEP_RD;
                end
            end

            S_SWEEP_RD:
            begin
                if (k_reg == '0)
                begin
                    state_next = S_RELEASE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = sweep_idx;
                    state_next  = S_SWEEP_WB;
                end
            end

            S_SWEEP_WB:
            begin
                if (mem_rd_data.pair == item_reg.pair_number)
                begin
                    freed_next = freed_reg + 1'b1;
                end
                else if (freed_reg != '0)
                begin
                    // slide the older entry up over the dropped ones
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = move_idx;
                    mem_wr_data = mem_rd_data;
                end
                k_next     = k_reg - 1'b1;
                state_next = S_SWEEP_RD;
            end

            S_RELEASE:
            begin
                if (k_reg < freed_reg)
                begin
                    sw_next[rel_idx] = 1'b0;
                    k_next           = k_reg + 1'b1;
                end
                else
                begin
                    ci_next                    = ci_reg + 16'(freed_reg);
                    res_next                   = '0;
                    res_next.status            = ST_CLEANED;
                    res_next.freed_count       = 8'(freed_reg);
                    res_next.consumer_position = ci_reg + 16'(freed_reg);
                    state_next                 = S_DONE;
                end
            end

            S_DONE:
            begin
                // hold until the result register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            sw_reg        <= '0;
            ci_reg        <= '0;
            run_reg       <= '0;
            k_reg         <= '0;
            freed_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            sw_reg        <= sw_next;
            ci_reg        <= ci_next;
            run_reg       <= run_next;
            k_reg         <= k_next;
            freed_reg     <= freed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/completion_ring_purge_core.sv
// Top level of the completion ring purge block: size register, sequencer and entry store.
//
// A completion ring whose entries (queue-pair number and payload) sit in one synchronous
// memory, while the owner bits sit in flip-flops that reset to hardware-owned. Each accepted
// transfer gives exactly one result transfer. A write is done at dispatch; a poll reads the
// consumer slot from memory only when it is software-owned. A clean over a software-owned run
// is dispatched, measures the run one owner bit a cycle, then sweeps each entry (memory read,
// then compare and write-back), returns the freed slots one per cycle, and loads the result
// register. The next request is taken once the current one has reached the result register.
// ring_size_log2 is to be written by the user only while the block is idle; the block itself
// does not enforce this. The size is clamped to 1..8 and to the ring depth.
module completion_ring_purge_core
    import crp_pkg::*;
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_t       rsp,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata
);

    localparam int DEPTH_LOG2 = $clog2(RING_DEPTH + 1) - 1;
    localparam int IDX_W      = (DEPTH_LOG2 > 8) ? 8 : DEPTH_LOG2;

    logic [3:0]       size_log2_reg;
    logic [3:0]       eff_log2;
    logic [IDX_W:0]   size_one_hot;
    logic [IDX_W-1:0] mask;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= LOG2_RESET;
        end
        else if (cfg_we)
        begin
            size_log2_reg <= cfg_wdata;
        end
    end

    // clamp the size to the legal range, then to the ring depth
    always_comb
    begin
        eff_log2 = size_log2_reg;
        if (eff_log2 < LOG2_MIN)
        begin
            eff_log2 = LOG2_MIN;
        end
        if (eff_log2 > LOG2_MAX)
        begin
            eff_log2 = LOG2_MAX;
        end
        if (eff_log2 > 4'(IDX_W))
        begin
            eff_log2 = 4'(IDX_W);
        end
        size_one_hot = (IDX_W + 1)'(1) << eff_log2;
        mask         = IDX_W'(size_one_hot - 1'b1);
    end

    crp_ctrl #(
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .mask        (mask),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    crp_ring_mem #(
        .IDX_W (IDX_W)
    ) u_ring_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

### test/completion_ring_purge_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the completion ring purge block.
module completion_ring_purge_core_test
    import crp_pkg::*;
;

    localparam int RING_DEPTH = 256;
    localparam int RANDOM_ITEMS = 1150;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        bit         is_cfg;
        logic [3:0] size_log2;
        req_t       item;
    } pending_op_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    req_t       req = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    rsp_t       rsp;
    logic       cfg_we = 1'b0;
    logic [3:0] cfg_wdata = LOG2_RESET;

    // Shadow copy of the ring, the consumer counter and the size register
    logic [23:0] shadow_pair [RING_DEPTH];
    logic [31:0] shadow_payload [RING_DEPTH];
    logic        shadow_owner [RING_DEPTH];
    logic [15:0] shadow_consumer = '0;
    logic [3:0]  shadow_log2 = LOG2_RESET;

    pending_op_t pending_ops [$];
    rsp_t        expected_results [$];

    int n_items = 0;
    int n_counted = 0;
    int n_done = 0;
    int n_errors = 0;
    int n_cycles = 0;
    int n_polled = 0;
    int n_empty = 0;
    int n_cleans = 0;
    int n_freed = 0;
    int n_cfg = 0;
    int gap_left = 0;
    int stall_left = 0;
    int settle = 0;
    bit quiet = 1'b0;

    completion_ring_purge_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic int ring_mask(logic [3:0] size_log2);
        int l;
        l = size_log2;
        if (l < LOG2_MIN) l = LOG2_MIN;
        if (l > LOG2_MAX) l = LOG2_MAX;
        return (1 << l) - 1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Apply one request to the shadow ring and return the result it should give
    function automatic rsp_t ring_step(req_t r);
        rsp_t o;
        int mask, ci, run, k, p, e, t, freed, s;
        o = '0;
        mask = ring_mask(shadow_log2);
        case (r.action)
            ACT_WRITE:
            begin
                s = r.slot & mask;
                shadow_pair[s] = r.pair_number;
                shadow_payload[s] = r.entry_payload;
                shadow_owner[s] = r.hw_owned;
                o.status = ST_WRITTEN;
            end
            ACT_POLL:
            begin
                s = shadow_consumer & mask;
                if (shadow_owner[s])
                begin
                    o.status = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    o.status = ST_POLLED;
                    o.out_pair_number = shadow_pair[s];
                    o.out_payload = shadow_payload[s];
                    shadow_owner[s] = 1'b1;
                    shadow_consumer = shadow_consumer + 16'd1;
                    n_polled++;
                end
            end
            ACT_CLEAN:
            begin
                ci = shadow_consumer;
                run = 0;
                freed = 0;
                while (run < mask && !shadow_owner[(ci + run) & mask]) run++;
                // sweep from the newest entry back, sliding survivors up over dropped ones
                for (k = run; k > 0; k--)
                begin
                    p = ci + k - 1;
                    e = p & mask;
                    if (shadow_pair[e] == r.pair_number)
                    begin
                        freed++;
                    end
                    else if (freed != 0)
                    begin
                        t = (p + freed) & mask;
                        shadow_pair[t] = shadow_pair[e];
                        shadow_payload[t] = shadow_payload[e];
                        shadow_owner[t] = shadow_owner[e];
                    end
                end
                for (k = 0; k < freed; k++) shadow_owner[(ci + k) & mask] = 1'b1;
                shadow_consumer = 16'(ci + freed);
                o.status = ST_CLEANED;
                o.freed_count = 8'(freed);
                n_cleans++;
                n_freed += freed;
            end
            default: o.status = ST_WRITTEN;
        endcase
        o.consumer_position = shadow_consumer;
        return o;
    endfunction

    task automatic push_item(logic [1:0] act, logic [7:0] slot, logic [23:0] pair,
                             logic [31:0] payload, logic owner);
        pending_op_t op;
        op.is_cfg = 1'b0;
        op.size_log2 = '0;
        op.item = '{action: act, slot: slot, pair_number: pair, entry_payload: payload,
                    hw_owned: owner};
        pending_ops.push_back(op);
        n_items++;
        if (act != ACT_UNUSED) n_counted++;
    endtask

    task automatic push_cfg(logic [3:0] size_log2);
        pending_op_t op;
        op.is_cfg = 1'b1;
        op.size_log2 = size_log2;
        op.item = '0;
        pending_ops.push_back(op);
    endtask

    task automatic push_noise();
        push_item(2'($urandom), 8'($urandom), 24'($urandom), $urandom, 1'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || n_done != n_items) @(posedge clk);
    endtask

    // One burst: optionally resize, then fill a software-owned run at the consumer
    // end and work it down with polls and cleans drawn from a small set of pairs
    task automatic build_phase();
        int mask, start, len, nops, i, r;
        logic [3:0] lg;
        logic [23:0] pool [3];
        lg = shadow_log2;
        if ($urandom_range(0, 2) == 0)
        begin
            r = $urandom_range(0, 9);
            if (r < 6) lg = 4'($urandom_range(1, 4));
            else if (r == 6) lg = LOG2_MAX;
            else if (r == 7) lg = ($urandom_range(0, 1) != 0) ? 4'd15 : 4'd0;
            else lg = 4'($urandom);
            push_cfg(lg);
        end
        mask = ring_mask(lg);
        quiet = ($urandom_range(0, 5) == 0);
        foreach (pool[j]) pool[j] = 24'($urandom);
        if ($urandom_range(0, 6) == 0)
        begin
            nops = $urandom_range(8, 20);
            for (i = 0; i < nops; i++) push_noise();
        end
        else
        begin
            start = shadow_consumer;
            if ($urandom_range(0, 19) == 0) len = mask + 1;
            else len = $urandom_range(1, (mask + 1 < 24) ? mask + 1 : 24);
            for (i = 0; i < len; i++)
                push_item(ACT_WRITE, 8'(((start + i) & mask) | ($urandom & ~mask)),
                          ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                      : pool[$urandom_range(0, 2)],
                          $urandom, ($urandom_range(0, 11) == 0));
            nops = $urandom_range(2, 10);
            for (i = 0; i < nops; i++)
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    push_item(ACT_CLEAN, 8'($urandom),
                              ($urandom_range(0, 5) == 0) ? 24'($urandom)
                                                          : pool[$urandom_range(0, 2)],
                              $urandom, 1'($urandom));
                else if (r < 9)
                    push_item(ACT_POLL, 8'($urandom), 24'($urandom), $urandom, 1'($urandom));
                else
                    push_noise();
            end
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Request driver; resizes only once every outstanding result has come back
    always @(posedge clk)
    begin
        pending_op_t op;
        if (rst_n)
        begin
            if (req_valid && !req_stall) expected_results.push_back(ring_step(req));
            if (req_valid && req_stall)
            begin
                // hold the stalled transfer
                cfg_we <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
                cfg_we <= 1'b0;
            end
            else if (pending_ops.size() != 0 && !pending_ops[0].is_cfg)
            begin
                op = pending_ops.pop_front();
                req <= op.item;
                req_valid <= 1'b1;
                cfg_we <= 1'b0;
                gap_left = pick_gap();
            end
            else if (pending_ops.size() != 0 && expected_results.size() == 0)
            begin
                req_valid <= 1'b0;
                if (settle < SETTLE_CYCLES)
                begin
                    settle++;
                    cfg_we <= 1'b0;
                end
                else
                begin
                    op = pending_ops.pop_front();
                    cfg_we <= 1'b1;
                    cfg_wdata <= op.size_log2;
                    shadow_log2 = op.size_log2;
                    n_cfg++;
                    settle = 0;
                end
            end
            else
            begin
                req_valid <= 1'b0;
                cfg_we <= 1'b0;
                settle = 0;
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, rsp);
                    n_errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("out_pair_number", want.out_pair_number, rsp.out_pair_number);
                    check_field("out_payload", want.out_payload, rsp.out_payload);
                    check_field("freed_count", want.freed_count, rsp.freed_count);
                    check_field("consumer_position", want.consumer_position,
                                rsp.consumer_position);
                    n_done++;
                end
            end
            if (stall_left > 0) stall_left--;
            else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            rsp_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     expected_results.size());
            $display("[completion_ring_purge_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        int base;
        foreach (shadow_owner[i])
        begin
            shadow_owner[i] = 1'b1;
            shadow_pair[i] = '0;
            shadow_payload[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty ring, unused code, then a short run with a hardware-owned stop
        push_item(ACT_POLL, 8'h00, 24'h000000, 32'h0, 1'b0);
        push_item(ACT_CLEAN, 8'h00, 24'h000000, 32'h0, 1'b0);
        push_item(ACT_UNUSED, 8'hFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b1);
        push_item(ACT_WRITE, 8'h00, 24'h000000, 32'h0000_0000, 1'b0);
        push_item(ACT_WRITE, 8'h01, 24'hFFFFFF, 32'hFFFF_FFFF, 1'b0);
        push_item(ACT_WRITE, 8'h02, 24'h000000, 32'h1234_5678, 1'b0);
        push_item(ACT_WRITE, 8'h03, 24'h000ABC, 32'h8000_0001, 1'b1);
        push_item(ACT_CLEAN, 8'h00, 24'h123456, 32'h0, 1'b0);
        push_item(ACT_CLEAN, 8'h00, 24'h000000, 32'h0, 1'b0);
        push_item(ACT_POLL, 8'h00, 24'h0, 32'h0, 1'b0);
        push_item(ACT_POLL, 8'h00, 24'h0, 32'h0, 1'b0);
        push_item(ACT_WRITE, 8'hFF, 24'h000005, 32'h0000_0001, 1'b0);
        // smallest ring: slots beyond it wrap, clean run capped at one entry
        push_cfg(4'd1);
        push_item(ACT_WRITE, 8'hFF, 24'h000007, 32'hA5A5_A5A5, 1'b0);
        push_item(ACT_WRITE, 8'hFE, 24'h000007, 32'h5A5A_5A5A, 1'b0);
        push_item(ACT_CLEAN, 8'h00, 24'h000007, 32'h0, 1'b0);
        push_item(ACT_POLL, 8'h00, 24'h0, 32'h0, 1'b0);
        push_item(ACT_POLL, 8'h00, 24'h0, 32'h0, 1'b0);
        // out-of-range sizes clamp to the extremes
        push_cfg(4'd0);
        push_item(ACT_WRITE, 8'h01, 24'h000009, 32'h0000_0009, 1'b0);
        push_item(ACT_POLL, 8'h00, 24'h0, 32'h0, 1'b0);
        push_cfg(4'd15);
        push_item(ACT_POLL, 8'h00, 24'h0, 32'h0, 1'b0);
        push_item(ACT_CLEAN, 8'h00, 24'h000005, 32'h0, 1'b0);
        wait_drained();

        base = n_counted;
        while (n_counted - base < RANDOM_ITEMS)
        begin
            build_phase();
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            n_errors++;
        end
        $display("Covered %0d requests over %0d size changes: %0d polled, %0d empty polls,",
                 n_items, n_cfg, n_polled, n_empty);
        $display("%0d cleans freeing %0d entries, %0d mismatches", n_cleans, n_freed, n_errors);
        if (n_errors == 0)
            $display("[completion_ring_purge_core] OK");
        else
            $display("[completion_ring_purge_core] ERROR");
        $finish;
    end

endmodule
